@@ rtl/zero_dim_persistence_pairing_macros.svh @@
// assertion macros for the checker file of the pairing block
// no dependencies; include by bare file name
`ifndef ZERO_DIM_PERSISTENCE_PAIRING_MACROS_SVH
`define ZERO_DIM_PERSISTENCE_PAIRING_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ZDPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zdpp check failed");

// next-cycle implication, disabled while reset is asserted
`define ZDPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zdpp check failed");

`endif

@@ rtl/zdpp_pkg.sv @@
// shared types and constants of the zero-dimensional persistence pairing block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package zdpp_pkg;

  // sizes
  localparam int NUM_VERTICES  = 1024;
  localparam int VERTEX_BITS   = $clog2(NUM_VERTICES);
  localparam int VALUE_BITS    = 32;

  // stream word widths, padded to whole bytes
  localparam int IN_FIELD_BITS  = 2 * VERTEX_BITS + VALUE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = VERTEX_BITS + 2 * VALUE_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // item kinds carried on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  typedef logic [VERTEX_BITS-1:0]       vertex_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  // one input word
  typedef struct packed {
    logic    func;
    vertex_t vertex_a;
    vertex_t vertex_b;
    value_t  vertex_value;
  } item_t;

  // one pair word
  typedef struct packed {
    vertex_t dying_vertex;
    value_t  birth_value;
    value_t  death_value;
  } result_t;

  // per-vertex union-find entry
  typedef struct packed {
    logic    paired;
    vertex_t elder;
    vertex_t parent;
  } node_t;

  // field write enables of the node memory
  typedef struct packed {
    logic paired;
    logic elder;
    logic parent;
  } node_wen_t;

endpackage

`default_nettype wire

@@ rtl/zdpp_engine.sv @@
// union-find sequencer with the vertex value and node memories
// depends on zdpp_pkg
`timescale 1ns / 1ps
`default_nettype none

module zdpp_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  zdpp_pkg::item_t   item_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output zdpp_pkg::result_t res_o
);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_FIND_A  = 4'd1;
  localparam logic [3:0] ST_FIND_B  = 4'd2;
  localparam logic [3:0] ST_RD_EA   = 4'd3;
  localparam logic [3:0] ST_RD_EB   = 4'd4;
  localparam logic [3:0] ST_WAIT_EB = 4'd5;
  localparam logic [3:0] ST_PAIR    = 4'd6;
  localparam logic [3:0] ST_WR_RA   = 4'd7;
  localparam logic [3:0] ST_WR_DY   = 4'd8;

  localparam zdpp_pkg::vertex_t LAST_STEP =
    zdpp_pkg::VERTEX_BITS'(zdpp_pkg::NUM_VERTICES - 1);

  // memories
  zdpp_pkg::value_t val_mem  [zdpp_pkg::NUM_VERTICES];
  zdpp_pkg::node_t  node_mem [zdpp_pkg::NUM_VERTICES];

  logic                val_we;
  zdpp_pkg::vertex_t   val_raddr;
  zdpp_pkg::value_t    val_rdata_q;
  zdpp_pkg::node_wen_t node_we;
  zdpp_pkg::vertex_t   node_waddr;
  zdpp_pkg::node_t     node_wdata;
  zdpp_pkg::vertex_t   node_raddr;
  zdpp_pkg::node_t     node_rdata_q;

  // control state
  logic [3:0] state_q, state_d;
  logic       first_q, first_d;
  logic       bound_q, bound_d;
  logic       vb_pend_q, vb_pend_d;

  // working registers
  zdpp_pkg::vertex_t a_q, a_d, b_q, b_d, cur_q, cur_d, cnt_q, cnt_d;
  zdpp_pkg::vertex_t ra_q, ra_d, rb_q, rb_d, ea_q, ea_d, eb_q, eb_d;
  zdpp_pkg::vertex_t dying_q, dying_d, me_q, me_d;
  logic              paired_a_q, paired_a_d, paired_b_q, paired_b_d;
  zdpp_pkg::value_t  va_q, va_d, vb_q, vb_d, vea_q, vea_d, veb_q, veb_d;

  // pair decision
  logic              a_is_elder, child_paired;
  zdpp_pkg::vertex_t child, ec, ee, dying, me;
  zdpp_pkg::value_t  v_child, vec, vee;

  logic accept;

  assign item_ready_o = (state_q == ST_IDLE);
  assign accept       = item_valid_i && item_ready_o;

  // value memory: written on loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[item_i.vertex_a] <= item_i.vertex_value;
    end
    val_rdata_q <= val_mem[val_raddr];
  end

  // node memory: field-masked write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (node_we.parent) begin
      node_mem[node_waddr].parent <= node_wdata.parent;
    end
    if (node_we.elder) begin
      node_mem[node_waddr].elder <= node_wdata.elder;
    end
    if (node_we.paired) begin
      node_mem[node_waddr].paired <= node_wdata.paired;
    end
    node_rdata_q <= node_mem[node_raddr];
  end

  // elder rule and pair choice from the gathered values
  always_comb begin
    a_is_elder   = (va_q <= vb_q);
    child        = a_is_elder ? b_q : a_q;
    child_paired = a_is_elder ? paired_b_q : paired_a_q;
    v_child      = a_is_elder ? vb_q : va_q;
    ec           = a_is_elder ? eb_q : ea_q;
    ee           = a_is_elder ? ea_q : eb_q;
    vec          = a_is_elder ? veb_q : vea_q;
    vee          = a_is_elder ? vea_q : veb_q;
    me           = (vea_q <= veb_q) ? ea_q : eb_q;
    res_o.death_value = (va_q >= vb_q) ? va_q : vb_q;
    if (!child_paired) begin
      dying             = child;
      res_o.birth_value = v_child;
    end else if (vec <= vee) begin
      dying             = ee;
      res_o.birth_value = vee;
    end else begin
      dying             = ec;
      res_o.birth_value = vec;
    end
    res_o.dying_vertex = dying;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    bound_d    = bound_q;
    vb_pend_d  = 1'b0;
    a_d        = a_q;
    b_d        = b_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    ea_d       = ea_q;
    eb_d       = eb_q;
    dying_d    = dying_q;
    me_d       = me_q;
    paired_a_d = paired_a_q;
    paired_b_d = paired_b_q;
    va_d       = va_q;
    vb_d       = vb_q;
    vea_d      = vea_q;
    veb_d      = veb_q;
    val_we     = 1'b0;
    val_raddr  = a_q;
    node_raddr = cur_q;
    node_we    = '0;
    node_waddr = ra_q;
    node_wdata = '0;
    res_valid_o = 1'b0;

    // value of the second endpoint lands in the cycle after its read
    if (vb_pend_q) begin
      vb_d = val_rdata_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.func == zdpp_pkg::FUNC_LOAD) begin
            // singleton: own root and elder, not paired
            val_we            = 1'b1;
            node_we           = '1;
            node_waddr        = item_i.vertex_a;
            node_wdata.paired = 1'b0;
            node_wdata.elder  = item_i.vertex_a;
            node_wdata.parent = item_i.vertex_a;
          end else begin
            a_d        = item_i.vertex_a;
            b_d        = item_i.vertex_b;
            cur_d      = item_i.vertex_a;
            cnt_d      = '0;
            bound_d    = 1'b0;
            first_d    = 1'b1;
            node_raddr = item_i.vertex_a;
            val_raddr  = item_i.vertex_a;
            state_d    = ST_FIND_A;
          end
        end
      end

      ST_FIND_A: begin
        if (first_q) begin
          paired_a_d = node_rdata_q.paired;
          va_d       = val_rdata_q;
          val_raddr  = b_q;
          vb_pend_d  = 1'b1;
          first_d    = 1'b0;
        end
        if (node_rdata_q.parent == cur_q || bound_q) begin
          ra_d       = cur_q;
          ea_d       = node_rdata_q.elder;
          cur_d      = b_q;
          cnt_d      = '0;
          bound_d    = 1'b0;
          first_d    = 1'b1;
          node_raddr = b_q;
          state_d    = ST_FIND_B;
        end else begin
          cur_d      = node_rdata_q.parent;
          node_raddr = node_rdata_q.parent;
          cnt_d      = cnt_q + 1'b1;
          bound_d    = (cnt_q == LAST_STEP);
        end
      end

      ST_FIND_B: begin
        if (first_q) begin
          paired_b_d = node_rdata_q.paired;
          first_d    = 1'b0;
        end
        if (node_rdata_q.parent == cur_q || bound_q) begin
          rb_d = cur_q;
          eb_d = node_rdata_q.elder;
          // same component: nothing to pair or merge
          state_d = (cur_q == ra_q) ? ST_IDLE : ST_RD_EA;
        end else begin
          cur_d      = node_rdata_q.parent;
          node_raddr = node_rdata_q.parent;
          cnt_d      = cnt_q + 1'b1;
          bound_d    = (cnt_q == LAST_STEP);
        end
      end

      ST_RD_EA: begin
        val_raddr = ea_q;
        state_d   = ST_RD_EB;
      end

      ST_RD_EB: begin
        val_raddr = eb_q;
        vea_d     = val_rdata_q;
        state_d   = ST_WAIT_EB;
      end

      ST_WAIT_EB: begin
        veb_d   = val_rdata_q;
        state_d = ST_PAIR;
      end

      ST_PAIR: begin
        // emit once the output slot is free, then hang rb under ra
        if (res_ready_i) begin
          res_valid_o       = 1'b1;
          node_we.parent    = 1'b1;
          node_we.elder     = 1'b1;
          node_waddr        = rb_q;
          node_wdata.parent = ra_q;
          node_wdata.elder  = me;
          dying_d           = dying;
          me_d              = me;
          state_d           = ST_WR_RA;
        end
      end

      ST_WR_RA: begin
        node_we.elder    = 1'b1;
        node_waddr       = ra_q;
        node_wdata.elder = me_q;
        state_d          = ST_WR_DY;
      end

      ST_WR_DY: begin
        node_we.paired    = 1'b1;
        node_waddr        = dying_q;
        node_wdata.paired = 1'b1;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      first_q   <= 1'b0;
      bound_q   <= 1'b0;
      vb_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      first_q   <= first_d;
      bound_q   <= bound_d;
      vb_pend_q <= vb_pend_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    cur_q      <= cur_d;
    cnt_q      <= cnt_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    dying_q    <= dying_d;
    me_q       <= me_d;
    paired_a_q <= paired_a_d;
    paired_b_q <= paired_b_d;
    va_q       <= va_d;
    vb_q       <= vb_d;
    vea_q      <= vea_d;
    veb_q      <= veb_d;
  end

endmodule

`default_nettype wire

@@ rtl/zero_dim_persistence_pairing.sv @@
// top level of the zero-dimensional persistence pairing block
// depends on zdpp_pkg and zdpp_engine
//
// usage:
//   input stream: tuser = 0 loads vertex_value into vertex_a and makes it a
//   singleton; tuser = 1 is an edge (vertex_a, vertex_b), sent in filtration
//   order. output stream: one word per edge that merges two components,
//   carrying the dying vertex, its birth value and the edge's death value.
// sequence:
//   a load is written as it is taken and the next word is taken after it.
//   an edge holds the input while the sequencer walks parent links from
//   each endpoint to its root, one read of the node memory per step, then
//   reads both component elders' values, emits its pair word into the
//   output register and writes back the merge. an edge inside one
//   component returns to idle after the two walks with no word.
// reset and stall:
//   reset clears the sequencer and the output valid; memory contents are
//   kept and every vertex must be loaded before an edge names it.
//   the pair word sits in an output register; while it is not taken, words
//   are accepted, but a further merging edge waits and holds the input.
`timescale 1ns / 1ps
`default_nettype none

module zero_dim_persistence_pairing (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // vertex_a [9:0], vertex_b [19:10], vertex_value [51:20], zero pad
  input  logic [zdpp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // dying_vertex [9:0], birth_value [41:10], death_value [73:42], zero pad
  output logic [zdpp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

  localparam int VB = zdpp_pkg::VERTEX_BITS;
  localparam int WB = zdpp_pkg::VALUE_BITS;

  zdpp_pkg::item_t   item;
  zdpp_pkg::result_t res;
  zdpp_pkg::result_t out_q;
  logic              res_valid;
  logic              slot_free;
  logic              out_valid_q;

  // unpack the input word
  assign item.func         = s_axis_tuser;
  assign item.vertex_a     = s_axis_tdata[VB-1:0];
  assign item.vertex_b     = s_axis_tdata[2*VB-1:VB];
  assign item.vertex_value = s_axis_tdata[2*VB+WB-1:2*VB];

  zdpp_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_ready_i  (slot_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // output register
  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  // pack the output word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (zdpp_pkg::OUT_TDATA_BITS - zdpp_pkg::OUT_FIELD_BITS)'(0),
    out_q.death_value,
    out_q.birth_value,
    out_q.dying_vertex
  };

endmodule

`default_nettype wire

@@ rtl/zdpp_checker.sv @@
// port-level checks of the pairing block and their bind to the top level
// depends on zdpp_pkg and zero_dim_persistence_pairing_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "zero_dim_persistence_pairing_macros.svh"

module zdpp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_i,
  input logic                                s_axis_tuser_i,
  input logic                                m_axis_tvalid_i,
  input logic                                m_axis_tready_i,
  input logic [zdpp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_i
);

  // an edge occupies the sequencer for at least the next cycle
  `ZDPP_ASSERT_NEXT(edge_busy, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_i && s_axis_tuser_i == zdpp_pkg::FUNC_EDGE, !s_axis_tready_i)

  // a load finishes in the cycle it is taken
  `ZDPP_ASSERT_NEXT(load_done, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_i && s_axis_tuser_i == zdpp_pkg::FUNC_LOAD, s_axis_tready_i)

  // a new pair word only comes from an edge still being written back
  `ZDPP_ASSERT_SAME(pair_from_edge, clk_i, rst_ni, $rose(m_axis_tvalid_i), !s_axis_tready_i)

  // a stalled pair word holds
  `ZDPP_ASSERT_NEXT(out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i))

endmodule

bind zero_dim_persistence_pairing zdpp_checker u_zdpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid),
  .s_axis_tready_i (s_axis_tready),
  .s_axis_tuser_i  (s_axis_tuser),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata)
);

`default_nettype wire

@@ bench/tb_zero_dim_persistence_pairing.sv @@
`timescale 1ns / 1ps
// self-checking bench for zero_dim_persistence_pairing: a union-find predictor
// with the elder rule checks every pair word; needs zdpp_pkg and the block rtl

module tb_zero_dim_persistence_pairing;
  import zdpp_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int ITEM_TARGET  = 1900;
  localparam int DRAIN_CYCLES = 2500;
  localparam int HOLD_CYCLES  = 400;

  // one edge of a generated graph, w is its filtration value
  typedef struct {
    vertex_t a;
    vertex_t b;
    value_t  w;
  } edge_rec_t;

  // union-find predictor and queue of pair words still to come
  class pair_scoreboard;
    vertex_t parent_of [NUM_VERTICES];
    value_t  value_of  [NUM_VERTICES];
    vertex_t elder_of  [NUM_VERTICES];
    bit      paired_of [NUM_VERTICES];
    result_t pending_pairs [$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function vertex_t root_of(input vertex_t v);
      int n;
      for (n = 0; n < NUM_VERTICES; n++) begin
        if (parent_of[v] == v) break;
        v = parent_of[v];
      end
      return v;
    endfunction

    // apply one accepted input word and queue the pair it causes
    function void note_word(input logic func, input vertex_t a, input vertex_t b,
                            input value_t v);
      vertex_t ra, rb, elder, child, dying, ea, eb, ec, ee, merged;
      result_t pw;
      if (func == FUNC_LOAD) begin
        value_of[a]  = v;
        parent_of[a] = a;
        elder_of[a]  = a;
        paired_of[a] = 1'b0;
        return;
      end
      ra = root_of(a);
      rb = root_of(b);
      // endpoints already joined: nothing happens
      if (ra == rb) return;
      if (value_of[a] <= value_of[b]) begin
        elder = a;
        child = b;
      end else begin
        elder = b;
        child = a;
      end
      // an unpaired child dies, else the younger of the two component elders
      if (!paired_of[child]) begin
        dying = child;
      end else begin
        ec = elder_of[root_of(child)];
        ee = elder_of[root_of(elder)];
        dying = (value_of[ec] <= value_of[ee]) ? ee : ec;
      end
      paired_of[dying] = 1'b1;
      pw.dying_vertex = dying;
      pw.birth_value  = value_of[dying];
      pw.death_value  = (value_of[a] >= value_of[b]) ? value_of[a] : value_of[b];
      pending_pairs.push_back(pw);
      // merge b's set under a's root, keep the older elder
      ea = elder_of[ra];
      eb = elder_of[rb];
      merged = (value_of[ea] <= value_of[eb]) ? ea : eb;
      parent_of[rb] = ra;
      elder_of[ra]  = merged;
      elder_of[rb]  = merged;
    endfunction

    // compare one accepted pair word with the oldest expectation
    function void check_pair(input logic [OUT_TDATA_BITS-1:0] word);
      result_t want;
      vertex_t got_vertex;
      value_t  got_birth, got_death;
      got_vertex = word[VERTEX_BITS-1:0];
      got_birth  = word[VERTEX_BITS +: VALUE_BITS];
      got_death  = word[VERTEX_BITS+VALUE_BITS +: VALUE_BITS];
      if (pending_pairs.size() == 0) begin
        $error("pair word with none expected: %h", word);
        errors++;
        return;
      end
      want = pending_pairs.pop_front();
      if (got_vertex !== want.dying_vertex) begin
        $error("dying_vertex: expected %0d, actual %0d", want.dying_vertex, got_vertex);
        errors++;
      end
      if (got_birth !== want.birth_value) begin
        $error("birth_value: expected %0d, actual %0d", want.birth_value, got_birth);
        errors++;
      end
      if (got_death !== want.death_value) begin
        $error("death_value: expected %0d, actual %0d", want.death_value, got_death);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // vertex_a [9:0], vertex_b [19:10], vertex_value [51:20], zero pad
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  // func
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // dying_vertex [9:0], birth_value [41:10], death_value [73:42], zero pad
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  pair_scoreboard pairs_sb;
  bit      loaded [NUM_VERTICES];
  vertex_t loaded_list [$];
  int      items_sent = 0;
  bit      send_burst = 1'b0;
  int      cycle_count = 0;

  zero_dim_persistence_pairing DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input logic func, input vertex_t a, input vertex_t b,
                           input value_t v);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= IN_TDATA_BITS'({v, b, a});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pairs_sb.note_word(func, a, b, v);
    items_sent++;
    if (func == FUNC_LOAD && !loaded[a]) begin
      loaded[a] = 1'b1;
      loaded_list.push_back(a);
    end
    // switch between gapped and back-to-back stretches
    if (items_sent % 97 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  // vertex value: extremes, a narrow band full of ties, or anything
  function automatic value_t draw_value(input bit narrow);
    case ($urandom_range(0, 9))
      0:       return value_t'(32'h8000_0000);
      1:       return value_t'(32'h7FFF_FFFF);
      default: return narrow ? value_t'(($urandom_range(0, 15) << 16) - 32'h0008_0000)
                             : value_t'($urandom());
    endcase
  endfunction

  // load a fresh vertex set, then send random edges in filtration order
  task automatic run_graph(input int n_vert, input int n_links);
    vertex_t   verts [$];
    value_t    vals [$];
    edge_rec_t links [$];
    edge_rec_t cur;
    bit        taken [NUM_VERTICES];
    vertex_t   cand;
    bit        narrow;
    int        i, j, ia, ib;
    narrow = $urandom_range(0, 1);
    while (verts.size() < n_vert) begin
      cand = vertex_t'($urandom_range(0, NUM_VERTICES - 1));
      if (!taken[cand]) begin
        taken[cand] = 1'b1;
        verts.push_back(cand);
        vals.push_back(draw_value(narrow));
      end
    end
    for (i = 0; i < n_vert; i++)
      send_word(FUNC_LOAD, verts[i], vertex_t'($urandom()), vals[i]);
    for (i = 0; i < n_links; i++) begin
      ia = $urandom_range(0, n_vert - 1);
      ib = $urandom_range(0, n_vert - 1);
      cur.a = verts[ia];
      cur.b = verts[ib];
      cur.w = (vals[ia] >= vals[ib]) ? vals[ia] : vals[ib];
      links.push_back(cur);
    end
    // sort by edge value
    for (i = 1; i < links.size(); i++) begin
      cur = links[i];
      j = i;
      while (j > 0 && links[j-1].w > cur.w) begin
        links[j] = links[j-1];
        j--;
      end
      links[j] = cur;
    end
    foreach (links[k])
      send_word(FUNC_EDGE, links[k].a, links[k].b, value_t'($urandom()));
  endtask

  // unordered loads and edges over everything loaded so far
  task automatic run_noise(input int n_items);
    int i;
    for (i = 0; i < n_items; i++) begin
      if (loaded_list.size() == 0 || $urandom_range(0, 3) == 0)
        send_word(FUNC_LOAD, vertex_t'($urandom()), vertex_t'($urandom()),
                  draw_value($urandom_range(0, 1)));
      else
        send_word(FUNC_EDGE, loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                  loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                  value_t'($urandom()));
    end
  endtask

  // pair word sink with random stalls and one long hold-off
  initial begin
    int  stall, taken_words, hold;
    bit  calm, held;
    taken_words = 0;
    calm = 1'b0;
    held = 1'b0;
    // the output valid is unknown until reset has been applied
    wait (rst_ni === 1'b1);
    forever begin
      if (taken_words == 40 && !held) begin
        // long hold-off so the block fills up and stalls its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(posedge clk_i);
          hold++;
        end
      end else begin
        stall = calm ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      pairs_sb.check_pair(m_axis_tdata);
      taken_words++;
      if (taken_words % 53 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  // reset, directed cases, random graphs, drain
  initial begin
    pairs_sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, ties and alternating index bits
    send_word(FUNC_LOAD, 10'd0,    10'd1023, value_t'(32'h8000_0000));
    send_word(FUNC_LOAD, 10'd1023, 10'd0,    value_t'(32'h7FFF_FFFF));
    send_word(FUNC_LOAD, 10'd5,    10'd341,  value_t'(32'h0000_0000));
    send_word(FUNC_LOAD, 10'd6,    10'd682,  value_t'(32'h0000_0000));
    send_word(FUNC_LOAD, 10'd7,    10'd0,    value_t'(32'h0001_0000));
    send_word(FUNC_LOAD, 10'd512,  10'd0,    value_t'(32'hFFFF_0000));
    send_word(FUNC_LOAD, 10'd341,  10'd0,    value_t'(32'h5555_5555));
    send_word(FUNC_LOAD, 10'd682,  10'd0,    value_t'(32'hAAAA_AAAA));
    // tie goes to the first endpoint
    send_word(FUNC_EDGE, 10'd5,    10'd6,    value_t'(32'hFFFF_FFFF));
    // same component, then a self-loop
    send_word(FUNC_EDGE, 10'd6,    10'd5,    value_t'(32'h0000_0000));
    send_word(FUNC_EDGE, 10'd7,    10'd7,    value_t'(32'h1234_5678));
    send_word(FUNC_EDGE, 10'd512,  10'd7,    value_t'(32'h0));
    // paired child: the younger component elder dies
    send_word(FUNC_EDGE, 10'd7,    10'd5,    value_t'(32'h0));
    send_word(FUNC_EDGE, 10'd1023, 10'd0,    value_t'(32'h0));
    send_word(FUNC_EDGE, 10'd0,    10'd6,    value_t'(32'h0));
    send_word(FUNC_EDGE, 10'd341,  10'd682,  value_t'(32'h0));
    // reload a vertex that sits inside a component
    send_word(FUNC_LOAD, 10'd6,    10'd1023, value_t'(32'h7FFF_FFFF));
    send_word(FUNC_EDGE, 10'd6,    10'd1023, value_t'(32'h0));
    send_word(FUNC_EDGE, 10'd682,  10'd6,    value_t'(32'h0));
    send_word(FUNC_EDGE, 10'd0,    10'd1023, value_t'(32'h0));

    // one large set, then mostly small sets with some noise
    run_graph(128, 200);
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8)
        run_graph($urandom_range(2, 24), 0);
      else
        run_noise($urandom_range(10, 30));
      if ($urandom_range(0, 1) == 1) run_graph($urandom_range(2, 16), $urandom_range(2, 40));
    end
    s_axis_tvalid <= 1'b0;

    while (pairs_sb.pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pairs_sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/zdpp_pkg.sv
rtl/zdpp_engine.sv
rtl/zero_dim_persistence_pairing.sv
rtl/zdpp_checker.sv
bench/tb_zero_dim_persistence_pairing.sv
